FILE: sv/cfb_pkg.sv
// Shared constants and types for the command frame builder.
package cfb_pkg;

    // Largest payload a frame carries; longer requests are clamped.
    localparam int MAX_DATA_BYTES = 4;
    // Bytes ahead of the payload: sync pair, control, length, sequence, command.
    localparam int HDR_BYTES      = 8;
    // Byte counter covers every header and payload position plus the end mark.
    localparam int IDX_W          = $clog2(HDR_BYTES + MAX_DATA_BYTES + 1);

    localparam logic [7:0]  SYNC0_BYTE = 8'h55;
    localparam logic [7:0]  SYNC1_BYTE = 8'h66;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // Frame positions of the header bytes.
    localparam logic [IDX_W-1:0] POS_SYNC0  = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_SYNC1  = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_CTRL   = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_LEN_LO = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_LEN_HI = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_SEQ_LO = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_SEQ_HI = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_CMD    = IDX_W'(7);

    // Control from the frame sequencer to the serial CRC unit.
    typedef struct packed {
        logic init;   // load the seed into the check register
        logic load;   // take a new byte and start shifting it in
    } crc_ctl_t;

endpackage

FILE: sv/cfb_crc_serial.sv
// Bit-serial CRC-16 unit: folds one byte into the check register, one bit per cycle.
module cfb_crc_serial (
    input  logic              clk,
    input  logic              rst_n,
    input  cfb_pkg::crc_ctl_t ctl,
    input  logic [15:0]       seed,
    input  logic [7:0]        data_byte,
    output logic [15:0]       crc,
    output logic              busy
);
    import cfb_pkg::*;

    logic [15:0] crc_reg,  crc_next;
    logic [7:0]  sh_reg,   sh_next;
    logic [2:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        fb;

    // MSB first: feedback is the register top bit against the next data bit.
    assign fb = crc_reg[15] ^ sh_reg[7];

    always_comb
    begin
        crc_next  = crc_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctl.init)
        begin
            crc_next = seed;
        end
        else if (busy_reg)
        begin
            crc_next = {crc_reg[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            sh_next  = {sh_reg[6:0], 1'b0};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
        if (ctl.load)
        begin
            sh_next   = data_byte;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        sh_reg  <= sh_next;
    end

    assign crc  = crc_reg;
    assign busy = busy_reg;

endmodule

FILE: sv/command_frame_builder_crc16.sv
// Top level of the command frame builder: sequencer, output register and seed register.
//
// Use: a request item (command_id, ack_flag, data_length, payload_bytes) enters on
// in_valid/in_stall and turns into one serial frame on out_valid/out_stall, one byte
// per output item: 0x55, 0x66, control, length (16 bit LE), sequence 0 (16 bit),
// command id, 0 to MAX_DATA_BYTES payload bytes, then the CRC-16 low and high byte.
// frame_end marks the CRC high byte. data_length above MAX_DATA_BYTES is clamped.
// The CRC (poly 0x1021, MSB first, no final xor) starts from seed_reg, written on
// cfg_we with cfg_wdata while the block is idle.
//
// Sequence: the check register takes one bit per cycle. Each header or payload byte
// is issued in ST_BYTE, its eight bits are shifted into the CRC unit, and ST_WAIT
// holds until the CRC unit is idle before the next byte is issued. The CRC low and
// high bytes follow the last payload byte; a new request is accepted only once the
// sequencer is back in ST_IDLE. out_valid rises once ST_BYTE fills the output slot.
//
// Reset: rst_n clears the sequencer, empties the output register and sets the seed
// to 0. A stalling receiver holds the output register; the sequencer waits for a
// free slot before issuing each byte, so nothing is dropped or repeated.
module command_frame_builder_crc16 (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  command_id,
    input  logic        ack_flag,
    input  logic [2:0]  data_length,
    input  logic [31:0] payload_bytes,
    // frame byte channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        frame_end
);
    import cfb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYTE,
        ST_WAIT,
        ST_CRC_LO,
        ST_CRC_HI
    } state_t;

    state_t             state_reg;
    logic [15:0]        seed_reg;
    logic [7:0]         cmd_reg;
    logic               ack_reg;
    logic [IDX_W-1:0]   len_reg;
    logic [31:0]        pay_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_end_reg;

    logic               in_accept;
    logic               out_free;
    logic               out_load;
    logic [7:0]         cur_byte;
    logic [IDX_W-1:0]   len_clamped;
    crc_ctl_t           crc_ctl;
    logic [15:0]        crc_val;
    logic               crc_busy;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    // Output slot takes a new byte when empty or being drained this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    // A byte enters the output slot from any issuing state once the slot is free.
    assign out_load  = out_free && (state_reg == ST_BYTE || state_reg == ST_CRC_LO
                                    || state_reg == ST_CRC_HI);

    assign len_clamped = (IDX_W'(data_length) > IDX_W'(MAX_DATA_BYTES))
                         ? IDX_W'(MAX_DATA_BYTES) : IDX_W'(data_length);

    // Pick the frame byte at the current position; payload comes off the low end
    // of the payload shift register.
    always_comb
    begin
        unique case (idx_reg)
            POS_SYNC0:  cur_byte = SYNC0_BYTE;
            POS_SYNC1:  cur_byte = SYNC1_BYTE;
            POS_CTRL:   cur_byte = {7'd0, ack_reg};
            POS_LEN_LO: cur_byte = 8'(len_reg);
            POS_LEN_HI: cur_byte = 8'h00;
            POS_SEQ_LO: cur_byte = 8'h00;
            POS_SEQ_HI: cur_byte = 8'h00;
            POS_CMD:    cur_byte = cmd_reg;
            default:    cur_byte = pay_reg[7:0];
        endcase
    end

    always_comb
    begin
        crc_ctl.init = in_accept;
        crc_ctl.load = (state_reg == ST_BYTE) && out_free;
    end

    cfb_crc_serial u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (crc_ctl),
        .seed      (seed_reg),
        .data_byte (cur_byte),
        .crc       (crc_val),
        .busy      (crc_busy)
    );

    // Seed register: the user must write it only while idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 16'h0000;
        end
        else if (cfg_we)
        begin
            seed_reg <= cfg_wdata;
        end
    end

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            // fill the slot on a new byte, drop the shown byte once taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_BYTE;
                    end
                end
                ST_BYTE:
                begin
                    if (out_free)
                    begin
                        out_end_reg   <= 1'b0;
                        idx_reg       <= idx_reg + IDX_W'(1);
                        state_reg     <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    // hold until all eight bits are folded in
                    if (!crc_busy)
                    begin
                        if (idx_reg == IDX_W'(HDR_BYTES) + len_reg)
                        begin
                            state_reg <= ST_CRC_LO;
                        end
                        else
                        begin
                            state_reg <= ST_BYTE;
                        end
                    end
                end
                ST_CRC_LO:
                begin
                    if (out_free)
                    begin
                        out_end_reg   <= 1'b0;
                        state_reg     <= ST_CRC_HI;
                    end
                end
                ST_CRC_HI:
                begin
                    if (out_free)
                    begin
                        out_end_reg   <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload-side registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= command_id;
            ack_reg <= ack_flag;
            len_reg <= len_clamped;
            pay_reg <= payload_bytes;
        end
        else if (state_reg == ST_BYTE && out_free && idx_reg >= IDX_W'(HDR_BYTES))
        begin
            // advance to the next payload byte; zeros fill in past the field
            pay_reg <= {8'h00, pay_reg[31:8]};
        end

        if (state_reg == ST_BYTE && out_free)
        begin
            out_byte_reg <= cur_byte;
        end
        else if (state_reg == ST_CRC_LO && out_free)
        begin
            out_byte_reg <= crc_val[7:0];
        end
        else if (state_reg == ST_CRC_HI && out_free)
        begin
            out_byte_reg <= crc_val[15:8];
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign frame_end  = out_end_reg;

endmodule

FILE: sv/cfb_checker.sv
// Port-level checks for the command frame builder, bound to the top level.
module cfb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] frame_byte,
    input logic       frame_end
);

    // A request just taken keeps the channel closed while its frame builds.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall
    ) else $error("request channel open right after accept");

    // An open request channel means no frame is half sent.
    a_idle_frame_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid || frame_end
    ) else $error("request accepted in the middle of a frame");

    // A frame byte shown right after the frame end is the first sync byte.
    a_frame_starts_sync: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && frame_end ##1 out_valid |-> frame_byte == 8'h55
    ) else $error("frame does not start with sync byte");

    // A stalled byte holds.
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(frame_end)
    ) else $error("stalled frame byte changed");

endmodule

bind command_frame_builder_crc16 cfb_checker u_cfb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .frame_end  (frame_end)
);

FILE: bench/command_frame_builder_crc16_test.sv
// Self-checking testbench for the command frame builder with CRC-16 framing.
module command_frame_builder_crc16_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cfb_pkg::*;

    // One expected byte of a serial frame.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_octet_t;

    // Directed request row; frame_bytes is the frame size read straight off the
    // layout (8 header bytes, clamped payload, 2 check bytes).
    typedef struct packed {
        logic [7:0]  cmd;
        logic        ack;
        logic [2:0]  len;
        logic [31:0] pay;
        logic [3:0]  frame_bytes;
    } request_row_t;

    localparam int DIRECTED_ROWS = 14;

    // Cover the zero-length frame, the field extremes, every legal length, and
    // lengths above the maximum that must be clamped to MAX_DATA_BYTES.
    localparam request_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{8'h00, 1'b0, 3'd0, 32'h0000_0000, 4'd10},   // empty payload, all zero
        '{8'hFF, 1'b1, 3'd4, 32'hFFFF_FFFF, 4'd14},   // every field at its top, length at MAX_DATA_BYTES
        '{8'hA5, 1'b0, 3'd1, 32'h0000_00A5, 4'd11},
        '{8'h5A, 1'b1, 3'd2, 32'h0000_C33C, 4'd12},
        '{8'h80, 1'b0, 3'd3, 32'h0012_3456, 4'd13},
        '{8'h01, 1'b1, 3'd4, 32'hDEAD_BEEF, 4'd14},
        '{8'h7F, 1'b0, 3'd5, 32'h0102_0304, 4'd14},   // length clamped
        '{8'h3C, 1'b1, 3'd6, 32'hAAAA_AAAA, 4'd14},   // length clamped
        '{8'hC3, 1'b0, 3'd7, 32'h5555_5555, 4'd14},   // largest length field
        '{8'h00, 1'b1, 3'd0, 32'hFFFF_FFFF, 4'd10},   // payload present but unused
        '{8'hFF, 1'b0, 3'd1, 32'hFFFF_FF00, 4'd11},
        '{8'h10, 1'b1, 3'd3, 32'h8000_0001, 4'd13},
        '{8'h42, 1'b0, 3'd4, 32'h0000_0000, 4'd14},
        '{8'hE7, 1'b1, 3'd7, 32'hFFFF_FFFF, 4'd14}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  command_id;
    logic        ack_flag;
    logic [2:0]  data_length;
    logic [31:0] payload_bytes;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  frame_byte;
    logic        frame_end;

    // Bytes still owed by the block, oldest first, and the typed frame sizes
    // (zero where the row carries none).
    frame_octet_t expected_frame_bytes[$];
    int           expected_frame_sizes[$];

    logic [15:0] seed_copy;          // mirror of the seed register
    int          mismatch_count;
    int          bytes_in_frame;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    bit          hold_receiver;      // ask the receiver for one long hold-off

    command_frame_builder_crc16 uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command_id    (command_id),
        .ack_flag      (ack_flag),
        .data_length   (data_length),
        .payload_bytes (payload_bytes),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_byte    (frame_byte),
        .frame_end     (frame_end)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Advance the check value by one byte, MSB first, polynomial CRC_POLY.
    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    // Add one byte at the tail of the expectation.
    function automatic void owe_octet(logic [7:0] b, logic last);
        frame_octet_t o;
        o.value = b;
        o.last  = last;
        expected_frame_bytes.insert(expected_frame_bytes.size(), o);
    endfunction

    // Append one frame byte to the expectation and fold it into the running check.
    function automatic void owe_byte(logic [7:0] b, ref logic [15:0] crc);
        owe_octet(b, 1'b0);
        crc = crc16_next(crc, b);
    endfunction

    // Work out the whole frame one request turns into, under the current seed.
    function automatic void build_expected_frame(logic [7:0] cmd, logic ack,
                                                 logic [2:0] len, logic [31:0] pay);
        logic [15:0] crc;
        int          n;
        logic [7:0]  b;
        crc = seed_copy;
        n   = (int'(len) > MAX_DATA_BYTES) ? MAX_DATA_BYTES : int'(len);
        owe_byte(SYNC0_BYTE, crc);
        owe_byte(SYNC1_BYTE, crc);
        owe_byte({7'd0, ack}, crc);
        owe_byte(8'(n), crc);          // length, low byte
        owe_byte(8'h00, crc);          // length, high byte
        owe_byte(8'h00, crc);          // sequence, always zero
        owe_byte(8'h00, crc);
        owe_byte(cmd, crc);
        for (int i = 0; i < n; i++)
        begin
            // bytes past the 32-bit payload field go out as zero
            b = (i < 4) ? pay[8*i +: 8] : 8'h00;
            owe_byte(b, crc);
        end
        owe_octet(crc[7:0], 1'b0);
        owe_octet(crc[15:8], 1'b1);
    endfunction

    // Offer one request, idling at random first; return once it is taken.
    task automatic send_request(logic [7:0] cmd, logic ack, logic [2:0] len,
                                logic [31:0] pay, int typed_size);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        command_id    <= cmd;
        ack_flag      <= ack;
        data_length   <= len;
        payload_bytes <= pay;
        // hold the item until an edge with stall low
        do
            @(posedge clk);
        while (in_stall);
        build_expected_frame(cmd, ack, len, pay);
        expected_frame_sizes.insert(expected_frame_sizes.size(), typed_size);
    endtask

    task automatic send_random_requests(int count);
        for (int k = 0; k < count; k++)
            send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         3'($urandom_range(0, 7)), 32'($urandom), 0);
    endtask

    // Drop valid and wait until every owed byte has come out.
    task automatic drain_frames();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_frame_bytes.size() != 0)
            @(posedge clk);
    endtask

    // Write the seed register; only called with the block idle.
    task automatic write_seed(logic [15:0] seed);
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seed_copy = seed;
    endtask

    // Receiver: stall at random, or hold off for a long stretch on request so
    // the block fills up and stalls the sender.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_receiver = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
            end
        end
    end

    // Compare each frame byte taken from the block with the oldest expectation.
    always @(posedge clk)
    begin
        frame_octet_t want;
        int           want_size;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frame_bytes.size() == 0)
            begin
                $display("%0t: frame byte expected none actual byte %h end %b",
                         $time, frame_byte, frame_end);
                mismatch_count++;
            end
            else
            begin
                want = expected_frame_bytes.pop_front();
                if (frame_byte !== want.value)
                begin
                    $display("%0t: frame_byte expected %h actual %h",
                             $time, want.value, frame_byte);
                    mismatch_count++;
                end
                if (frame_end !== want.last)
                begin
                    $display("%0t: frame_end expected %b actual %b",
                             $time, want.last, frame_end);
                    mismatch_count++;
                end
            end
            bytes_in_frame++;
            if (frame_end === 1'b1)
            begin
                if (expected_frame_sizes.size() != 0)
                begin
                    want_size = expected_frame_sizes.pop_front();
                    if (want_size != 0 && want_size != bytes_in_frame)
                    begin
                        $display("%0t: frame size expected %0d actual %0d",
                                 $time, want_size, bytes_in_frame);
                        mismatch_count++;
                    end
                end
                bytes_in_frame = 0;
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        // Drive every input to a known value from time zero.
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= 16'h0000;
        in_valid           <= 1'b0;
        command_id         <= 8'h00;
        ack_flag           <= 1'b0;
        data_length        <= 3'd0;
        payload_bytes      <= 32'h0;
        seed_copy          = 16'h0000;   // seed after reset
        mismatch_count     = 0;
        bytes_in_frame     = 0;
        sender_idle_pct    = 15;
        receiver_stall_pct = 15;
        hold_receiver      = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run on the reset seed.
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_request(DIRECTED[r].cmd, DIRECTED[r].ack, DIRECTED[r].len,
                         DIRECTED[r].pay, int'(DIRECTED[r].frame_bytes));
        drain_frames();

        // All-ones seed with random idling on both sides.
        write_seed(16'hFFFF);
        send_random_requests(70);
        drain_frames();

        // Zero seed written back, no idling anywhere: back-to-back traffic.
        write_seed(16'h0000);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_random_requests(70);
        drain_frames();

        // Random seed; the receiver holds off long while requests keep coming.
        write_seed(16'($urandom));
        sender_idle_pct    = 15;
        receiver_stall_pct = 15;
        hold_receiver      = 1'b1;
        send_random_requests(80);
        drain_frames();

        // Seed with only the top bit set.
        write_seed(16'h8000);
        send_random_requests(80);
        drain_frames();

        // Let any stray bytes surface before the verdict.
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && expected_frame_bytes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
